// ===== hw/rtl/fta_pkg.sv =====
// ----------------------------------------------------------------------------
// fta_pkg: shared definitions for the fair ticket admission queue
// Command and status codes, port field widths and the control/status
// structs that join the sequencer to the datapath.
// ----------------------------------------------------------------------------
package fta_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int TICKET_BITS_DEF = 32;

  localparam int TICKET_W    = 32;
  localparam int COUNT_W     = 5;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ADMIT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_RUN_LIMIT = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADM_LIMIT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] RUN_LIMIT_RST = 5'd1;
  localparam logic [CFG_DATA_W-1:0] ADM_LIMIT_RST = 5'd16;

  typedef struct packed {
    logic                accept;
    logic                clear_all;
    logic                next_cand;
    logic                scan_start;
    logic                append;
    logic                run_set;
    logic                run_clr;
    logic                shift_start;
    logic                wait_dec;
    logic                status_en;
    logic [STATUS_W-1:0] status;
    logic                load_out;
  } fta_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             adm_full;
    logic             scan_done;
    logic             w_hit;
    logic             w_head;
    logic             r_hit;
    logic             start_room;
    logic             key_zero;
    logic             tries_done;
    logic             shift_done;
    logic             out_free;
  } fta_stat_t;

endpackage

// ===== hw/rtl/fta_ctrl.sv =====
// ----------------------------------------------------------------------------
// fta_ctrl: command sequencer
// Accepts one item at a time and steps the datapath through scan, update,
// shift and result phases.
// ----------------------------------------------------------------------------
module fta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  fta_pkg::fta_stat_t stat,
  output fta_pkg::fta_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_CAND  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          fta_pkg::CMD_ADMIT: begin
            if (stat.adm_full) begin
              cmd.status_en = 1'b1;
              cmd.status    = fta_pkg::ST_REFUSED;
              state_nxt     = S_RESP;
            end else begin
              state_nxt = S_CAND;
            end
          end
          fta_pkg::CMD_START, fta_pkg::CMD_CANCEL, fta_pkg::CMD_FINISH: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          fta_pkg::CMD_CLEAR: begin
            cmd.clear_all = 1'b1;
            cmd.status_en = 1'b1;
            cmd.status    = fta_pkg::ST_OK;
            state_nxt     = S_RESP;
          end
          default: begin
            cmd.status_en = 1'b1;
            cmd.status    = fta_pkg::ST_REFUSED;
            state_nxt     = S_RESP;
          end
        endcase
      end
      S_CAND: begin
        cmd.next_cand  = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.status_en = 1'b1;
        cmd.status    = fta_pkg::ST_REFUSED;
        state_nxt     = S_RESP;
        case (stat.op)
          fta_pkg::CMD_ADMIT: begin
            if (!stat.w_hit && !stat.r_hit && !stat.key_zero) begin
              cmd.append = 1'b1;
              cmd.status = fta_pkg::ST_OK;
            end else if (!stat.tries_done) begin
              cmd.status_en = 1'b0;
              state_nxt     = S_CAND;
            end
          end
          fta_pkg::CMD_START: begin
            if (stat.start_room && stat.w_head) begin
              cmd.run_set     = 1'b1;
              cmd.shift_start = 1'b1;
              cmd.status      = fta_pkg::ST_OK;
              state_nxt       = S_SHIFT;
            end else if (stat.w_hit) begin
              cmd.status = fta_pkg::ST_QUEUED;
            end
          end
          fta_pkg::CMD_CANCEL: begin
            if (stat.w_hit) begin
              cmd.shift_start = 1'b1;
              cmd.status      = fta_pkg::ST_OK;
              state_nxt       = S_SHIFT;
            end else if (stat.r_hit) begin
              cmd.run_clr = 1'b1;
              cmd.status  = fta_pkg::ST_OK;
            end
          end
          fta_pkg::CMD_FINISH: begin
            if (stat.r_hit) begin
              cmd.run_clr = 1'b1;
              cmd.status  = fta_pkg::ST_OK;
            end
          end
          default: begin
            cmd.status = fta_pkg::ST_REFUSED;
          end
        endcase
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.wait_dec = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fta_dp.sv =====
// ----------------------------------------------------------------------------
// fta_dp: ticket stores, scan engine and result register
// Waiting line and running tickets sit in memories; one registered read per
// cycle drives the search scan and the line compaction after a removal.
// ----------------------------------------------------------------------------
module fta_dp #(
  parameter int ENTRIES     = fta_pkg::ENTRIES_DEF,
  parameter int TICKET_BITS = fta_pkg::TICKET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fta_pkg::fta_cmd_t                  cmd,
  output fta_pkg::fta_stat_t                 stat,
  input  logic [fta_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [fta_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                               cfg_valid,
  input  logic [fta_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [fta_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [fta_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [fta_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int KW   = $clog2(ENTRIES + 2);
  localparam int LW   = (CW > fta_pkg::COUNT_W) ? CW : fta_pkg::COUNT_W;
  localparam int TB   = TICKET_BITS;
  localparam int PADW = fta_pkg::OUT_TDATA_W - 2 * fta_pkg::COUNT_W - fta_pkg::TICKET_W;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic [TB-1:0] wmem [ENTRIES];
  logic [TB-1:0] rmem [ENTRIES];
  logic [TB-1:0] wdata_r, rdata_r;

  logic [fta_pkg::CFG_DATA_W-1:0] rl_r, al_r;
  logic [fta_pkg::CMD_W-1:0]      op_r;
  logic [TB-1:0]                  key_r, next_r, issued_r;
  logic [KW-1:0]                  k_r;
  logic [CW-1:0]                  wc_r, rcnt_r;
  logic [ENTRIES-1:0]             rvalid_r;
  logic                           sc_run_r, rd_v_r;
  logic [IW-1:0]                  sc_addr_r, rd_idx_r;
  logic                           w_hit_r, r_hit_r, f_hit_r;
  logic [IW-1:0]                  w_pos_r, r_pos_r, f_pos_r;
  logic                           sh_on_r, sh_wv_r;
  logic [CW-1:0]                  sh_rd_r;
  logic [IW-1:0]                  sh_wa_r;
  logic [fta_pkg::STATUS_W-1:0]   res_status_r;
  logic                           out_valid_r;
  logic [fta_pkg::STATUS_W-1:0]   out_status_r;
  logic [fta_pkg::TICKET_W-1:0]   out_ticket_r;
  logic [fta_pkg::COUNT_W-1:0]    out_running_r, out_queued_r;

  logic [IW-1:0] rd_addr;
  logic [TB-1:0] next_p1, next_inc;
  logic [LW-1:0] rl_w, al_w, er_w, ea_w;
  logic [CW-1:0] eff_run, eff_adm;

  assign rl_w = LW'(rl_r);
  assign al_w = LW'(al_r);

  always_comb begin
    er_w = (rl_w == '0) ? LW'(1) : rl_w;
    if (er_w > LW'(ENTRIES)) begin
      er_w = LW'(ENTRIES);
    end
    ea_w = (al_w > er_w) ? al_w : er_w;
    if (ea_w > LW'(ENTRIES)) begin
      ea_w = LW'(ENTRIES);
    end
  end

  assign eff_run  = CW'(er_w);
  assign eff_adm  = CW'(ea_w);
  assign next_p1  = next_r + 1'b1;
  assign next_inc = (next_p1 == '0) ? TB'(1) : next_p1;
  assign rd_addr  = sc_run_r ? sc_addr_r : sh_rd_r[IW-1:0];

  assign stat.op         = op_r;
  assign stat.adm_full   = (({1'b0, wc_r} + {1'b0, rcnt_r}) >= {1'b0, eff_adm}) ||
                           (wc_r == CW'(ENTRIES));
  assign stat.scan_done  = rd_v_r && (rd_idx_r == LAST);
  assign stat.w_hit      = w_hit_r;
  assign stat.w_head     = w_hit_r && (w_pos_r == '0);
  assign stat.r_hit      = r_hit_r;
  assign stat.start_room = (rcnt_r < eff_run) && (wc_r != '0);
  assign stat.key_zero   = (key_r == '0);
  assign stat.tries_done = (k_r > KW'(eff_adm));
  assign stat.shift_done = !sh_on_r && !sh_wv_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      wmem[wc_r[IW-1:0]] <= key_r;
    end else if (sh_wv_r) begin
      wmem[sh_wa_r] <= wdata_r;
    end
    if (cmd.run_set) begin
      rmem[f_pos_r] <= key_r;
    end
    wdata_r <= wmem[rd_addr];
    rdata_r <= rmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_tuser;
      issued_r <= '0;
    end
    if (cmd.accept) begin
      key_r <= TB'(in_tdata);
    end else if (cmd.next_cand) begin
      key_r <= next_r;
    end
    if (cmd.append) begin
      issued_r <= key_r;
    end
    if (cmd.status_en) begin
      res_status_r <= cmd.status;
    end
    rd_idx_r <= sc_addr_r;
    if (rd_v_r) begin
      if (!w_hit_r && (CW'(rd_idx_r) < wc_r) && (wdata_r == key_r)) begin
        w_pos_r <= rd_idx_r;
      end
      if (!r_hit_r && rvalid_r[rd_idx_r] && (rdata_r == key_r)) begin
        r_pos_r <= rd_idx_r;
      end
      if (!f_hit_r && !rvalid_r[rd_idx_r]) begin
        f_pos_r <= rd_idx_r;
      end
    end
    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_ticket_r  <= fta_pkg::TICKET_W'(issued_r);
      out_running_r <= fta_pkg::COUNT_W'(rcnt_r);
      out_queued_r  <= fta_pkg::COUNT_W'(wc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_r        <= fta_pkg::RUN_LIMIT_RST;
      al_r        <= fta_pkg::ADM_LIMIT_RST;
      next_r      <= TB'(1);
      k_r         <= '0;
      wc_r        <= '0;
      rcnt_r      <= '0;
      rvalid_r    <= '0;
      sc_run_r    <= 1'b0;
      sc_addr_r   <= '0;
      rd_v_r      <= 1'b0;
      w_hit_r     <= 1'b0;
      r_hit_r     <= 1'b0;
      f_hit_r     <= 1'b0;
      sh_on_r     <= 1'b0;
      sh_wv_r     <= 1'b0;
      sh_rd_r     <= '0;
      sh_wa_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_addr)
          fta_pkg::CFG_RUN_LIMIT: rl_r <= cfg_data;
          fta_pkg::CFG_ADM_LIMIT: al_r <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.accept) begin
        k_r <= '0;
      end else if (cmd.next_cand) begin
        k_r    <= k_r + 1'b1;
        next_r <= next_inc;
      end

      if (cmd.scan_start) begin
        sc_run_r  <= 1'b1;
        sc_addr_r <= '0;
        w_hit_r   <= 1'b0;
        r_hit_r   <= 1'b0;
        f_hit_r   <= 1'b0;
      end else if (sc_run_r) begin
        if (sc_addr_r == LAST) begin
          sc_run_r <= 1'b0;
        end else begin
          sc_addr_r <= sc_addr_r + 1'b1;
        end
      end
      rd_v_r <= sc_run_r;

      if (rd_v_r) begin
        if (!w_hit_r && (CW'(rd_idx_r) < wc_r) && (wdata_r == key_r)) begin
          w_hit_r <= 1'b1;
        end
        if (!r_hit_r && rvalid_r[rd_idx_r] && (rdata_r == key_r)) begin
          r_hit_r <= 1'b1;
        end
        if (!f_hit_r && !rvalid_r[rd_idx_r]) begin
          f_hit_r <= 1'b1;
        end
      end

      if (cmd.shift_start) begin
        sh_on_r <= 1'b1;
        sh_wv_r <= 1'b0;
        sh_rd_r <= CW'(w_pos_r) + 1'b1;
      end else if (sh_on_r) begin
        if (sh_rd_r < wc_r) begin
          sh_wv_r <= 1'b1;
          sh_wa_r <= IW'(sh_rd_r - 1'b1);
          sh_rd_r <= sh_rd_r + 1'b1;
        end else begin
          sh_on_r <= 1'b0;
          sh_wv_r <= 1'b0;
        end
      end else begin
        sh_wv_r <= 1'b0;
      end

      if (cmd.append) begin
        wc_r <= wc_r + 1'b1;
      end else if (cmd.wait_dec) begin
        wc_r <= wc_r - 1'b1;
      end

      if (cmd.run_set) begin
        rvalid_r[f_pos_r] <= 1'b1;
        rcnt_r            <= rcnt_r + 1'b1;
      end else if (cmd.run_clr) begin
        rvalid_r[r_pos_r] <= 1'b0;
        rcnt_r            <= rcnt_r - 1'b1;
      end

      if (cmd.clear_all) begin
        wc_r     <= '0;
        rcnt_r   <= '0;
        rvalid_r <= '0;
        next_r   <= TB'(1);
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PADW{1'b0}}, out_queued_r, out_running_r, out_ticket_r};

endmodule

// ===== hw/rtl/fair_ticket_admission_queue.sv =====
// ----------------------------------------------------------------------------
// fair_ticket_admission_queue: FIFO-fair ticketed admission controller
// Issues tickets into a waiting line and admits the line head to run.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command item per handshake; in_tuser carries the command,
//           in_tdata the ticket named by start, cancel or finish.
//   out_* : one result item per command; out_tuser carries the status,
//           out_tdata the issued ticket and both counts after the command.
//   cfg_* : limit register writes, always ready; write only while idle.
// Sequencing: one command at a time; the next is accepted once the result
//   is loaded into the output register. Clear, admits refused as full and
//   unused codes go straight to the result. Start, cancel and finish run one
//   scan of both stores; a removal from the waiting line then moves each
//   waiting entry behind it up one place. An admit runs one scan for each
//   ticket number it tries, up to admission limit plus one tries.
//   The scan rate is set by the single registered read port of each store.
// Reset: both stores empty, next ticket 1, limits 1 and 16; no sweep needed.
// Stall: a result waits in the output register while out_tready is low;
//   the next command is still taken and held until the register frees.
// ----------------------------------------------------------------------------
module fair_ticket_admission_queue #(
  parameter int ENTRIES     = fta_pkg::ENTRIES_DEF,
  parameter int TICKET_BITS = fta_pkg::TICKET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fta_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] ticket_in
  input  logic [fta_pkg::IN_TUSER_W-1:0]  in_tuser,   // [2:0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] ticket_out, [36:32] running_count, [41:37] queued_count, [47:42] zero
  output logic [fta_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [fta_pkg::OUT_TUSER_W-1:0] out_tuser,  // [1:0] status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fta_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [fta_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fta_pkg::fta_cmd_t  cmd;
  fta_pkg::fta_stat_t stat;

  assign cfg_ready = 1'b1;

  fta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fta_dp #(
    .ENTRIES     (ENTRIES),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/fta_checker.sv =====
// ----------------------------------------------------------------------------
// fta_checker: port-level checks for the fair ticket admission queue
// Tracks items in flight and checks result behaviour seen at the ports.
// ----------------------------------------------------------------------------
module fta_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fta_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [fta_pkg::OUT_TUSER_W-1:0] out_tuser
);

  logic [2:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_tvalid && in_tready) - 3'(out_tvalid && out_tready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_ticket_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[fta_pkg::TICKET_W-1:0] != '0) |-> out_tuser == fta_pkg::ST_OK)
    else $error("ticket issued without success status");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != '0)
    else $error("result without an accepted item");

endmodule

bind fair_ticket_admission_queue fta_checker u_fta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
